>>> rtl/vgp_pkg.sv
`default_nettype none
package vgp_pkg;
    localparam int DEPTH = 4096;
    localparam int AW    = 12;
    localparam int CW    = 13;
    localparam int SW    = 16;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic signed [16:0] INV_E_Q16 = 17'sd24109;

    localparam logic [1:0] CFG_PEAK_FLOOR  = 2'd0;
    localparam logic [1:0] CFG_VETO_LENGTH = 2'd1;
    localparam logic [1:0] CFG_EDGE_SKIP   = 2'd2;
    localparam logic [1:0] CFG_TIME_STEP   = 2'd3;

    typedef struct packed {
        logic [AW-1:0]        addr;
        logic signed [SW-1:0] smp;
        logic                 veto;
        logic                 wr;
        logic                 last;
        logic [CW-1:0]        fill;
        logic                 ovf;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] peak_floor;
        logic [11:0]        veto_length;
        logic [10:0]        edge_skip;
        logic [15:0]        time_step;
    } t_cfg;
endpackage
`default_nettype wire

>>> rtl/vgp_front.sv
`default_nettype none
module vgp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic signed [15:0] i_sample,
    input  wire logic            i_veto,
    input  wire logic            i_last,
    output logic                 busy,
    output vgp_pkg::t_cmd        o_cmd,
    output logic                 o_cmd_vld,
    input  wire logic            i_cmd_pop,
    input  wire logic            i_done
);
    import vgp_pkg::*;

    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic          r_hold;
    t_cmd          r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          accept, pop;
    t_cmd          n_cmd;

    assign busy      = (r_cnt == 2'd2) || r_hold;
    assign accept    = start && !busy;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign pop       = i_cmd_pop && o_cmd_vld;
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        n_cmd.wr   = (r_fill < DEPTH_C);
        n_cmd.addr = r_fill[AW-1:0];
        n_cmd.smp  = i_sample;
        n_cmd.veto = i_veto;
        n_cmd.last = i_last;
        n_cmd.fill = n_cmd.wr ? r_fill + CW'(1) : r_fill;
        n_cmd.ovf  = r_ovf | !n_cmd.wr;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_hold <= 1'b0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_wp <= !r_wp;
                if (i_last) begin
                    r_fill <= '0;
                    r_ovf  <= 1'b0;
                    r_hold <= 1'b1;
                end else begin
                    r_fill <= n_cmd.fill;
                    r_ovf  <= n_cmd.ovf;
                end
            end
            if (i_done) begin
                r_hold <= 1'b0;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/vgp_back.sv
`default_nettype none
module vgp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire vgp_pkg::t_cfg   i_cfg,
    input  wire vgp_pkg::t_cmd   i_cmd,
    input  wire logic            i_cmd_vld,
    output logic                 o_cmd_pop,
    output logic                 o_done,
    output logic                 o_valid,
    output logic [27:0]          o_rise_time,
    output logic signed [15:0]   o_peak_value,
    output logic [11:0]          o_peak_index,
    output logic [11:0]          o_decay_index,
    output logic                 o_peak_found,
    output logic                 o_record_overflow
);
    import vgp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_P1, S_THR, S_P2, S_MUL, S_OUT} t_state;

    t_state               r_st;
    logic signed [SW-1:0] r_mem_s [DEPTH];
    logic                 r_mem_v [DEPTH];
    logic signed [SW-1:0] r_rd_s;
    logic                 r_rd_v;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;
    logic [CW-1:0]        r_addr, r_hi;
    logic                 r_ovf;
    logic [11:0]          r_cd;
    logic signed [SW-1:0] r_best, r_below;
    logic [AW-1:0]        r_bidx, r_lidx;
    logic                 r_found;
    logic signed [32:0]   r_thr;
    logic [27:0]          r_rise;
    logic                 r_vld;
    logic                 issue;
    logic [11:0]          cd0;
    logic [CW-1:0]        two_edge;
    logic [27:0]          prod;

    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_vld;
    assign issue = ((r_st == S_P1) && (r_addr < r_hi)) ||
                   ((r_st == S_P2) && (r_addr != '0));
    assign cd0 = (r_rd_v && r_cd == 12'd0) ? i_cfg.veto_length : r_cd;
    assign two_edge = {1'b0, i_cfg.edge_skip, 1'b0};
    assign prod = 28'({16'b0, r_bidx - r_lidx} * {12'b0, i_cfg.time_step});
    assign o_done = (r_st == S_OUT);

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.wr) begin
            r_mem_s[i_cmd.addr] <= i_cmd.smp;
            r_mem_v[i_cmd.addr] <= i_cmd.veto;
        end
        if (issue) begin
            r_rd_s   <= r_mem_s[r_addr[AW-1:0]];
            r_rd_v   <= r_mem_v[r_addr[AW-1:0]];
            r_rd_idx <= r_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            case (r_st)
                S_IDLE: begin
                    r_vld <= 1'b0;
                    if (o_cmd_pop && i_cmd.last) begin
                        r_ovf   <= i_cmd.ovf;
                        r_best  <= i_cfg.peak_floor;
                        r_bidx  <= '0;
                        r_found <= 1'b0;
                        r_cd    <= '0;
                        if (i_cmd.fill > two_edge) begin
                            r_addr <= {2'b0, i_cfg.edge_skip};
                            r_hi   <= i_cmd.fill - {2'b0, i_cfg.edge_skip};
                        end else begin
                            r_addr <= '0;
                            r_hi   <= '0;
                        end
                        r_st <= S_P1;
                    end
                end
                S_P1: begin
                    if (issue) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    if (r_rd_vld) begin
                        if (cd0 == 12'd0 && r_rd_s > r_best) begin
                            r_best  <= r_rd_s;
                            r_bidx  <= r_rd_idx;
                            r_found <= 1'b1;
                        end
                        r_cd <= (cd0 != 12'd0) ? cd0 - 12'd1 : 12'd0;
                    end
                    if (!issue && !r_rd_vld) begin
                        r_st <= S_THR;
                    end
                end
                S_THR: begin
                    r_thr   <= $signed({{17{r_best[SW-1]}}, r_best}) *
                               $signed({16'b0, INV_E_Q16});
                    r_below <= '0;
                    r_lidx  <= '0;
                    r_addr  <= (r_bidx == '0) ? '0 : {1'b0, r_bidx - AW'(1)};
                    r_st    <= S_P2;
                end
                S_P2: begin
                    if (issue) begin
                        r_addr <= r_addr - CW'(1);
                    end
                    if (r_rd_vld && r_rd_s > r_below &&
                        ($signed({r_rd_s, 16'b0}) < r_thr)) begin
                        r_below <= r_rd_s;
                        r_lidx  <= r_rd_idx;
                    end
                    if (!issue && !r_rd_vld) begin
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rise <= prod;
                    r_vld  <= 1'b1;
                    r_st   <= S_OUT;
                end
                S_OUT: begin
                    r_vld <= 1'b0;
                    r_st  <= S_IDLE;
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_vld;
    assign o_rise_time       = r_rise;
    assign o_peak_value      = r_best;
    assign o_peak_index      = r_bidx;
    assign o_decay_index     = r_lidx;
    assign o_peak_found      = r_found;
    assign o_record_overflow = r_ovf;

    a_hi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_P1 && r_hi != '0) |-> (r_addr <= r_hi))
        else $error("peak scan address past upper bound");
    a_decay_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_decay_index < o_peak_index || o_decay_index == '0))
        else $error("decay index not below peak index");
    a_no_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_peak_found) |-> (o_peak_index == '0 && o_rise_time == '0))
        else $error("result without peak carries an index");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_cmd_pop)
        else $error("queue popped during search");
endmodule
`default_nettype wire

>>> rtl/veto_gated_pulse_rc_time.sv
// Pulse rise-time measurement with veto gating.
// Input: one sample per transaction on start/busy, with i_sample, i_veto and
// i_last. A transaction is taken at a clock edge with start high and busy low.
// Samples are queued and written to a 4096-entry record store, one per cycle
// while no search runs; samples beyond the store depth are dropped and flagged.
// On the sample with i_last set the block goes busy and scans the record twice:
// a peak scan over fill-2*edge_skip samples and a 1/e scan over peak_index-1
// samples, each one store read per cycle.
// busy drops when the result has been shown.
// Result: o_valid is high for one cycle with all fields; the receiver cannot
// stall and must take it then.
// Configuration: i_cfg_we, i_cfg_addr and i_cfg_data write a register at once;
// the user writes only while the block is idle; the block does not check it.
// Reset (synchronous, active low) restores register defaults and clears the
// record state; the store contents are left as they were.
`default_nettype none
module veto_gated_pulse_rc_time (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_sample,
    input  wire logic               i_veto,
    input  wire logic               i_last,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_valid,
    output logic [27:0]             o_rise_time,
    output logic signed [15:0]      o_peak_value,
    output logic [11:0]             o_peak_index,
    output logic [11:0]             o_decay_index,
    output logic                    o_peak_found,
    output logic                    o_record_overflow
);
    import vgp_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_vld, cmd_pop, done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_floor  <= 16'sd16;
            r_cfg.veto_length <= 12'd150;
            r_cfg.edge_skip   <= 11'd20;
            r_cfg.time_step   <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PEAK_FLOOR:  r_cfg.peak_floor  <= i_cfg_data;
                CFG_VETO_LENGTH: r_cfg.veto_length <= i_cfg_data[11:0];
                CFG_EDGE_SKIP:   r_cfg.edge_skip   <= i_cfg_data[10:0];
                CFG_TIME_STEP:   r_cfg.time_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vgp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_sample  (i_sample),
        .i_veto    (i_veto),
        .i_last    (i_last),
        .busy      (busy),
        .o_cmd     (cmd),
        .o_cmd_vld (cmd_vld),
        .i_cmd_pop (cmd_pop),
        .i_done    (done)
    );

    vgp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd),
        .i_cmd_vld         (cmd_vld),
        .o_cmd_pop         (cmd_pop),
        .o_done            (done),
        .o_valid           (o_valid),
        .o_rise_time       (o_rise_time),
        .o_peak_value      (o_peak_value),
        .o_peak_index      (o_peak_index),
        .o_decay_index     (o_decay_index),
        .o_peak_found      (o_peak_found),
        .o_record_overflow (o_record_overflow)
    );
endmodule
`default_nettype wire

>>> dv/rise_time_checker.sv
`timescale 1ns / 1ps
module rise_time_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [15:0] i_sample,
    input  wire logic               i_veto,
    input  wire logic               i_last,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               o_valid,
    input  wire logic [27:0]        o_rise_time,
    input  wire logic signed [15:0] o_peak_value,
    input  wire logic [11:0]        o_peak_index,
    input  wire logic [11:0]        o_decay_index,
    input  wire logic               o_peak_found,
    input  wire logic               o_record_overflow,
    output int                      o_errors,
    output int                      o_pending
);
    import vgp_pkg::*;

    typedef struct packed {
        logic [27:0]        rise_time;
        logic signed [15:0] peak_value;
        logic [11:0]        peak_index;
        logic [11:0]        decay_index;
        logic               peak_found;
        logic               record_overflow;
    } t_rise_result;

    t_rise_result       rise_results_q[$];
    logic signed [15:0] sample_mem [DEPTH];
    logic               veto_mem [DEPTH];
    int                 fill;
    logic               ovf;
    logic signed [15:0] floor_r;
    logic [11:0]        veto_len_r;
    logic [10:0]        edge_r;
    logic [15:0]        step_r;

    assign o_pending = rise_results_q.size();

    function automatic t_rise_result measure_record();
        t_rise_result r;
        int           best, bidx, below, didx, cd, i;
        longint       thr;
        bit           found;
        best  = floor_r;
        bidx  = 0;
        cd    = 0;
        found = 0;
        if (fill > 2 * int'(edge_r)) begin
            for (i = edge_r; i < fill - int'(edge_r); i++) begin
                if (veto_mem[i] && cd == 0) cd = veto_len_r;
                if (cd == 0 && sample_mem[i] > best) begin
                    best  = sample_mem[i];
                    bidx  = i;
                    found = 1;
                end
                if (cd > 0) cd--;
            end
        end
        below = 0;
        didx  = 0;
        thr   = longint'(best) * longint'(INV_E_Q16);
        for (i = bidx - 1; i > 0; i--) begin
            if (sample_mem[i] > below && longint'(sample_mem[i]) * 65536 < thr) begin
                below = sample_mem[i];
                didx  = i;
            end
        end
        r.rise_time       = 28'(longint'(bidx - didx) * longint'(step_r));
        r.peak_value      = 16'(best);
        r.peak_index      = 12'(bidx);
        r.decay_index     = 12'(didx);
        r.peak_found      = found;
        r.record_overflow = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rise_result got, want;
        if (!i_rst_n) begin
            o_errors   = 0;
            fill       = 0;
            ovf        = 0;
            floor_r    = 16;
            veto_len_r = 150;
            edge_r     = 20;
            step_r     = 1000;
        end else begin
            if (o_valid) begin
                got = '{o_rise_time, o_peak_value, o_peak_index, o_decay_index,
                        o_peak_found, o_record_overflow};
                if (rise_results_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %p", got);
                end else begin
                    want = rise_results_q.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PEAK_FLOOR:  floor_r    = i_cfg_data;
                    CFG_VETO_LENGTH: veto_len_r = i_cfg_data[11:0];
                    CFG_EDGE_SKIP:   edge_r     = i_cfg_data[10:0];
                    CFG_TIME_STEP:   step_r     = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (fill < DEPTH) begin
                    sample_mem[fill] = i_sample;
                    veto_mem[fill]   = i_veto;
                    fill++;
                end else begin
                    ovf = 1;
                end
                if (i_last) begin
                    rise_results_q.push_back(measure_record());
                    fill = 0;
                    ovf  = 0;
                end
            end
        end
    end
endmodule

>>> dv/veto_gated_pulse_rc_time_tb.sv
`timescale 1ns / 1ps
module veto_gated_pulse_rc_time_tb;
    import vgp_pkg::*;

    logic               i_clk;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [15:0] i_sample = 0;
    logic               i_veto = 0;
    logic               i_last = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_addr = CFG_PEAK_FLOOR;
    logic [15:0]        i_cfg_data = 0;
    logic               o_valid;
    logic [27:0]        o_rise_time;
    logic signed [15:0] o_peak_value;
    logic [11:0]        o_peak_index;
    logic [11:0]        o_decay_index;
    logic               o_peak_found;
    logic               o_record_overflow;
    int                 errors, pending;
    int                 idle_pct = 0;
    int                 sent = 0;

    veto_gated_pulse_rc_time u_dut (.*);
    rise_time_checker u_chk (.*, .o_errors(errors), .o_pending(pending));

    always begin
        i_clk = 1; #1;
        i_clk = 0; #1;
    end

    task automatic send_sample(input logic signed [15:0] s, input logic v, input logic l);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        start    = 1;
        i_sample = s;
        i_veto   = v;
        i_last   = l;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        start = 0;
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_we   = 1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic send_record(input int len, input int shape);
        int k, pk, amp;
        logic signed [15:0] s;
        pk  = $urandom_range(0, len - 1);
        amp = $urandom_range(0, 32767);
        for (k = 0; k < len; k++) begin
            if (shape == 0) s = 16'($urandom);
            else if (k <= pk) s = 16'(amp * (k + 1) / (pk + 1) + $urandom_range(0, 7) - 3);
            else s = 16'(amp / (k - pk + 1) - int'($urandom_range(0, 3)));
            send_sample(s, $urandom_range(99) < 5, k == len - 1);
        end
    endtask

    initial begin
        int n, len;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        send_sample(16'sd100, 0, 1);
        write_reg(CFG_EDGE_SKIP, 0);
        write_reg(CFG_VETO_LENGTH, 2);
        write_reg(CFG_PEAK_FLOOR, 16'h8000);
        write_reg(CFG_TIME_STEP, 16'hFFFF);
        send_sample(16'sh8000, 0, 0);
        send_sample(16'sd12000, 0, 0);
        send_sample(16'sd12000, 0, 0);
        send_sample(16'sd32767, 1, 0);
        send_sample(16'sd32767, 0, 0);
        send_sample(16'sd32767, 0, 0);
        send_sample(16'sd30000, 0, 1);
        send_sample(16'sh8000, 0, 1);
        write_reg(CFG_VETO_LENGTH, 0);
        write_reg(CFG_PEAK_FLOOR, 16'h7FFF);
        send_sample(16'sd5, 1, 0);
        send_sample(16'sd32767, 1, 1);
        write_reg(CFG_PEAK_FLOOR, 0);
        write_reg(CFG_EDGE_SKIP, 1);
        send_sample(16'sd1, 0, 0);
        send_sample(16'sd3, 0, 0);
        send_sample(16'sd8, 0, 0);
        send_sample(16'sd8, 0, 0);
        send_sample(16'sd20, 0, 0);
        send_sample(-16'sd4, 0, 1);
        write_reg(CFG_EDGE_SKIP, 2047);
        send_sample(16'sd9, 0, 1);
        write_reg(CFG_EDGE_SKIP, 0);
        write_reg(CFG_VETO_LENGTH, 4095);
        send_sample(16'sd9, 1, 0);
        send_sample(16'sd50, 0, 1);
        n = 0;
        while (sent < 1300 + DEPTH) begin
            if (n % 40 == 0) idle_pct = (n / 40) % 4 == 0 ? 0 :
                                        (n / 40) % 4 == 1 ? 74 :
                                        (n / 40) % 4 == 2 ? 0 : 14;
            if (n % 8 == 0) begin
                case ($urandom_range(3))
                    0: write_reg(CFG_PEAK_FLOOR, $urandom_range(3) == 0 ? 16'($urandom) :
                                 16'($urandom_range(0, 40)) - 16'd20);
                    1: write_reg(CFG_VETO_LENGTH, $urandom_range(4) == 0 ? 16'd4095 :
                                 16'($urandom_range(0, 12)));
                    2: write_reg(CFG_EDGE_SKIP, $urandom_range(5) == 0 ? 16'd2047 :
                                 16'($urandom_range(0, 4)));
                    default: write_reg(CFG_TIME_STEP, $urandom_range(2) == 0 ? 16'hFFFF :
                                       16'($urandom));
                endcase
            end
            if (n == 30) len = DEPTH + 3;
            else len = $urandom_range(9) == 0 ? $urandom_range(41, 200) : $urandom_range(1, 40);
            send_record(len, $urandom_range(3) == 0 ? 0 : 1);
            n++;
        end
        @(negedge i_clk);
        start = 0;
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("veto_gated_pulse_rc_time_tb: done, clean");
        end else begin
            $display("veto_gated_pulse_rc_time_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("veto_gated_pulse_rc_time_tb: done, errors");
        $finish;
    end
endmodule
